// ===== rtl/core/ppq_pkg.sv =====
// Package for the process priority queue: sizes, the entry record, operation
// and cell command codes. Used by ppq_cell and process_priority_queue; no dependencies.
package ppq_pkg;

  localparam int QUEUE_DEPTH    = 32;
  localparam int PRIORITY_WIDTH = 8;
  localparam int ID_W           = 5;
  localparam int PRIO_PORT_W    = 8;
  localparam int COUNT_PORT_W   = 6;
  localparam int COUNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef logic [ID_W-1:0]           id_t;
  typedef logic [PRIORITY_WIDTH-1:0] prio_t;
  typedef logic [COUNT_W-1:0]        count_t;

  typedef enum logic [1:0] {
    MODE_INSERT    = 2'd0,
    MODE_POP_HEAD  = 2'd1,
    MODE_REMOVE_ID = 2'd2,
    MODE_PEEK      = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CMD_HOLD = 2'd0,
    CMD_LOAD = 2'd1,
    CMD_PREV = 2'd2,
    CMD_NEXT = 2'd3
  } cmd_t;

  typedef struct packed {
    logic  valid;
    id_t   id;
    prio_t prio;
  } entry_t;

  typedef struct packed {
    logic ge;
    logic hit;
    logic first;
  } cell_flags_t;

endpackage

// ===== rtl/core/ppq_cell.sv =====
// One slot of the sorted queue: holds an entry and compares it with the
// incoming key. Depends on ppq_pkg.
module ppq_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  ppq_pkg::cmd_t       cmd,
  input  ppq_pkg::entry_t     new_entry,
  input  ppq_pkg::entry_t     prev_entry,
  input  ppq_pkg::entry_t     next_entry,
  input  logic                hit_in,
  output ppq_pkg::entry_t     entry,
  output ppq_pkg::cell_flags_t flags
);
  import ppq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;
  logic   match;

  assign match       = entry_r.valid && (entry_r.id == new_entry.id);
  assign flags.ge    = entry_r.valid && (entry_r.prio >= new_entry.prio);
  assign flags.hit   = hit_in | match;
  assign flags.first = match & ~hit_in;
  assign entry       = entry_r;

  always_comb begin
    case (cmd)
      CMD_LOAD: entry_nxt = new_entry;
      CMD_PREV: entry_nxt = prev_entry;
      CMD_NEXT: entry_nxt = next_entry;
      default:  entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

endmodule

// ===== rtl/core/process_priority_queue.sv =====
// Top level of the process priority queue: a row of ppq_cell slots with the
// control that steers them and the registered result port. Depends on ppq_pkg.
//
// The queue keeps process identifiers sorted by descending priority, with
// equal priorities served in arrival order. An item is taken at every clock
// edge with start high, and busy never rises, so one item can be given in
// every cycle. Its result appears on the out_ ports for exactly one cycle,
// marked by out_valid, in the cycle after the item was taken; the receiver
// must be ready for it then. Every slot compares itself with the incoming
// key and moves one place in the same cycle.
module process_priority_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_mode,
  input  logic [ppq_pkg::ID_W-1:0]          in_proc_id,
  input  logic [ppq_pkg::PRIO_PORT_W-1:0]   in_priority_req,
  output logic                              out_valid,
  output logic                              out_ok,
  output logic [ppq_pkg::ID_W-1:0]          out_id,
  output logic [ppq_pkg::PRIO_PORT_W-1:0]   out_priority,
  output logic                              out_is_empty,
  output logic [ppq_pkg::COUNT_PORT_W-1:0]  out_entry_count
);
  import ppq_pkg::*;

  entry_t      entries [QUEUE_DEPTH];
  entry_t      prev_of [QUEUE_DEPTH];
  entry_t      next_of [QUEUE_DEPTH];
  cell_flags_t flags   [QUEUE_DEPTH];
  logic        hit_in  [QUEUE_DEPTH];
  cmd_t        cmds    [QUEUE_DEPTH];
  entry_t      key;
  mode_t       mode;
  logic        accept;
  logic        full;
  logic        empty;
  logic        found;
  entry_t      found_entry;
  logic        res_ok;
  entry_t      res_entry;
  count_t      count_r;
  count_t      count_nxt;
  logic        out_valid_r;
  logic        out_ok_r;
  id_t         out_id_r;
  prio_t       out_prio_r;
  logic        out_empty_r;
  count_t      out_count_r;

  assign busy   = 1'b0;
  assign accept = start;
  assign mode   = mode_t'(in_mode);
  assign key.valid = 1'b1;
  assign key.id    = in_proc_id;
  assign key.prio  = prio_t'(in_priority_req);

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_head
        assign prev_of[g] = '0;
        assign hit_in[g]  = 1'b0;
      end else begin : g_body
        assign prev_of[g] = entries[g-1];
        assign hit_in[g]  = flags[g-1].hit;
      end
      if (g == QUEUE_DEPTH - 1) begin : g_tail
        assign next_of[g] = '0;
      end else begin : g_inner
        assign next_of[g] = entries[g+1];
      end

      always_comb begin
        cmds[g] = CMD_HOLD;
        if (accept) begin
          unique case (mode)
            MODE_INSERT: begin
              if (!full && !flags[g].ge) begin
                if (g == 0) begin
                  cmds[g] = CMD_LOAD;
                end else if (flags[(g == 0) ? 0 : g-1].ge) begin
                  cmds[g] = CMD_LOAD;
                end else begin
                  cmds[g] = CMD_PREV;
                end
              end
            end
            MODE_POP_HEAD: begin
              if (!empty) begin
                cmds[g] = CMD_NEXT;
              end
            end
            MODE_REMOVE_ID: begin
              if (flags[g].hit) begin
                cmds[g] = CMD_NEXT;
              end
            end
            default: cmds[g] = CMD_HOLD;
          endcase
        end
      end

      ppq_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmds[g]),
        .new_entry  (key),
        .prev_entry (prev_of[g]),
        .next_entry (next_of[g]),
        .hit_in     (hit_in[g]),
        .entry      (entries[g]),
        .flags      (flags[g])
      );
    end
  endgenerate

  assign full  = entries[QUEUE_DEPTH-1].valid;
  assign empty = ~entries[0].valid;
  assign found = flags[QUEUE_DEPTH-1].hit;

  always_comb begin
    found_entry = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (flags[i].first) begin
        found_entry = found_entry | entries[i];
      end
    end
  end

  always_comb begin
    res_ok    = 1'b0;
    res_entry = '0;
    count_nxt = count_r;
    unique case (mode)
      MODE_INSERT: begin
        if (!full) begin
          res_ok    = 1'b1;
          res_entry = key;
          count_nxt = count_r + count_t'(1);
        end
      end
      MODE_POP_HEAD: begin
        if (!empty) begin
          res_ok    = 1'b1;
          res_entry = entries[0];
          count_nxt = count_r - count_t'(1);
        end
      end
      MODE_REMOVE_ID: begin
        if (found) begin
          res_ok    = 1'b1;
          res_entry = found_entry;
          count_nxt = count_r - count_t'(1);
        end
      end
      default: begin
        if (!empty) begin
          res_ok    = 1'b1;
          res_entry = entries[0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
    if (accept) begin
      out_ok_r    <= res_ok;
      out_id_r    <= res_entry.id;
      out_prio_r  <= res_entry.prio;
      out_empty_r <= (count_nxt == '0);
      out_count_r <= count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_id          = out_id_r;
  assign out_priority    = PRIO_PORT_W'(out_prio_r);
  assign out_is_empty    = out_empty_r;
  assign out_entry_count = COUNT_PORT_W'(out_count_r);

endmodule

// ===== tb/sv/ppq_order_checker.sv =====
`timescale 1ns / 1ps
// Checker for the process priority queue: follows every accepted item, keeps its
// own sorted copy of the queue and compares every result strobe field by field.
// Depends on ppq_pkg.
module ppq_order_checker
  import ppq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic [1:0]               in_mode,
  input  logic [ID_W-1:0]          in_proc_id,
  input  logic [PRIO_PORT_W-1:0]   in_priority_req,
  input  logic                     out_valid,
  input  logic                     out_ok,
  input  logic [ID_W-1:0]          out_id,
  input  logic [PRIO_PORT_W-1:0]   out_priority,
  input  logic                     out_is_empty,
  input  logic [COUNT_PORT_W-1:0]  out_entry_count,
  output int                       errors,
  output int                       pending,
  output int                       checked,
  output int                       refusals
);

  typedef struct packed {
    logic                    ok;
    id_t                     id;
    logic [PRIO_PORT_W-1:0]  prio;
    logic                    empty;
    logic [COUNT_PORT_W-1:0] count;
  } queue_reply_t;

  id_t          slot_id   [QUEUE_DEPTH];
  prio_t        slot_prio [QUEUE_DEPTH];
  int           depth_used = 0;
  queue_reply_t awaited_replies[$];
  int           mismatch_count = 0;
  int           reply_count = 0;
  int           refusal_count = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void drop_slot(input int pos);
    for (int i = pos; i + 1 < depth_used; i++) begin
      slot_id[i]   = slot_id[i + 1];
      slot_prio[i] = slot_prio[i + 1];
    end
    depth_used--;
  endfunction

  function automatic queue_reply_t apply_queue_op(input mode_t op, input id_t pid,
                                                  input prio_t pri);
    queue_reply_t reply;
    int           pos;
    reply = '0;
    pos = 0;
    case (op)
      MODE_INSERT: begin
        if (depth_used < QUEUE_DEPTH) begin
          // A new item goes behind every entry of greater or equal priority.
          while (pos < depth_used && slot_prio[pos] >= pri) pos++;
          for (int i = depth_used; i > pos; i--) begin
            slot_id[i]   = slot_id[i - 1];
            slot_prio[i] = slot_prio[i - 1];
          end
          slot_id[pos]   = pid;
          slot_prio[pos] = pri;
          depth_used++;
          reply.ok   = 1'b1;
          reply.id   = pid;
          reply.prio = pri;
        end else begin
          refusal_count++;
        end
      end
      MODE_POP_HEAD: begin
        if (depth_used > 0) begin
          reply.ok   = 1'b1;
          reply.id   = slot_id[0];
          reply.prio = slot_prio[0];
          drop_slot(0);
        end
      end
      MODE_REMOVE_ID: begin
        while (pos < depth_used && slot_id[pos] != pid) pos++;
        if (pos < depth_used) begin
          reply.ok   = 1'b1;
          reply.id   = slot_id[pos];
          reply.prio = slot_prio[pos];
          drop_slot(pos);
        end
      end
      default: begin
        if (depth_used > 0) begin
          reply.ok   = 1'b1;
          reply.id   = slot_id[0];
          reply.prio = slot_prio[0];
        end
      end
    endcase
    reply.empty = (depth_used == 0);
    reply.count = depth_used[COUNT_PORT_W-1:0];
    return reply;
  endfunction

  always @(posedge clk) begin : watch_channels
    queue_reply_t want;
    if (!rst_n) begin
      depth_used = 0;
      awaited_replies.delete();
    end else begin
      if (out_valid) begin
        reply_count++;
        if (awaited_replies.size() == 0) begin
          report_mismatch("result strobe with no item outstanding");
        end else begin
          want = awaited_replies.pop_front();
          if (out_ok !== want.ok)
            report_mismatch($sformatf("ok got %0d, expected %0d", out_ok, want.ok));
          if (out_id !== want.id)
            report_mismatch($sformatf("id got %0d, expected %0d", out_id, want.id));
          if (out_priority !== want.prio)
            report_mismatch($sformatf("priority got %0d, expected %0d",
                                      out_priority, want.prio));
          if (out_is_empty !== want.empty)
            report_mismatch($sformatf("empty flag got %0d, expected %0d",
                                      out_is_empty, want.empty));
          if (out_entry_count !== want.count)
            report_mismatch($sformatf("entry count got %0d, expected %0d",
                                      out_entry_count, want.count));
        end
      end
      if (start && !busy)
        awaited_replies.push_back(apply_queue_op(mode_t'(in_mode), in_proc_id,
                                                 in_priority_req[PRIORITY_WIDTH-1:0]));
    end
    pending  <= awaited_replies.size();
    errors   <= mismatch_count;
    checked  <= reply_count;
    refusals <= refusal_count;
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Top of the process priority queue testbench: clock, reset, stimulus and verdict.
// Depends on ppq_pkg, process_priority_queue and ppq_order_checker.
module tb;
  import ppq_pkg::*;

  localparam int IDLE_LIMIT = 1000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               in_mode = 2'b00;
  logic [ID_W-1:0]          in_proc_id = '0;
  logic [PRIO_PORT_W-1:0]   in_priority_req = '0;
  logic                     out_valid;
  logic                     out_ok;
  logic [ID_W-1:0]          out_id;
  logic [PRIO_PORT_W-1:0]   out_priority;
  logic                     out_is_empty;
  logic [COUNT_PORT_W-1:0]  out_entry_count;

  int fail_count;
  int awaiting;
  int replies_checked;
  int full_refusals;
  int sent_per_mode[4] = '{0, 0, 0, 0};
  int idle_cycles = 0;

  always #5 clk = ~clk;

  process_priority_queue u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_proc_id      (in_proc_id),
    .in_priority_req (in_priority_req),
    .out_valid       (out_valid),
    .out_ok          (out_ok),
    .out_id          (out_id),
    .out_priority    (out_priority),
    .out_is_empty    (out_is_empty),
    .out_entry_count (out_entry_count)
  );

  ppq_order_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_proc_id      (in_proc_id),
    .in_priority_req (in_priority_req),
    .out_valid       (out_valid),
    .out_ok          (out_ok),
    .out_id          (out_id),
    .out_priority    (out_priority),
    .out_is_empty    (out_is_empty),
    .out_entry_count (out_entry_count),
    .errors          (fail_count),
    .pending         (awaiting),
    .checked         (replies_checked),
    .refusals        (full_refusals)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int k;
    k = $urandom_range(99);
    if (k < 55) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input mode_t op, input id_t pid, input logic [7:0] pri,
                           input int gap);
    in_mode         <= op;
    in_proc_id      <= pid;
    in_priority_req <= pri;
    start           <= 1'b1;
    do @(posedge clk); while (busy);
    sent_per_mode[op]++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  initial begin : stimulus
    int    random_sent;
    int    phase_idx;
    int    ins_weight;
    int    id_top;
    int    draw;
    bit    tie_prios;
    bit    no_idle;
    mode_t op;
    id_t   pid;
    logic [7:0] pri;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Empty queue: every removal and the peek must fail.
    send_item(MODE_PEEK, 5'd31, 8'hFF, pick_gap());
    send_item(MODE_POP_HEAD, 5'd0, 8'h00, pick_gap());
    send_item(MODE_REMOVE_ID, 5'd5, 8'h00, pick_gap());
    // Extremes, ties served in arrival order, and alternating bit patterns.
    send_item(MODE_INSERT, 5'd0, 8'h00, pick_gap());
    send_item(MODE_INSERT, 5'd31, 8'hFF, pick_gap());
    send_item(MODE_INSERT, 5'd7, 8'd128, pick_gap());
    send_item(MODE_INSERT, 5'd8, 8'd128, pick_gap());
    send_item(MODE_INSERT, 5'd9, 8'd128, pick_gap());
    send_item(MODE_INSERT, 5'd3, 8'h00, pick_gap());
    send_item(MODE_INSERT, 5'd21, 8'hAA, pick_gap());
    send_item(MODE_INSERT, 5'd10, 8'h55, pick_gap());
    send_item(MODE_PEEK, 5'd0, 8'h00, pick_gap());
    send_item(MODE_REMOVE_ID, 5'd8, 8'h00, pick_gap());
    send_item(MODE_REMOVE_ID, 5'd20, 8'hFF, pick_gap());
    send_item(MODE_INSERT, 5'd7, 8'h01, pick_gap());
    send_item(MODE_REMOVE_ID, 5'd7, 8'h00, pick_gap());
    repeat (7) send_item(MODE_POP_HEAD, 5'd0, 8'h00, pick_gap());
    send_item(MODE_POP_HEAD, 5'd31, 8'hFF, pick_gap());
    send_item(MODE_PEEK, 5'd0, 8'h00, pick_gap());

    random_sent = 0;
    phase_idx = 0;
    while (random_sent < 600) begin
      // The first phase fills the queue so that refused inserts are seen early.
      if (phase_idx == 0) begin
        ins_weight = 85;
      end else begin
        case ($urandom_range(2))
          0: ins_weight = 85;
          1: ins_weight = 15;
          default: ins_weight = 50;
        endcase
      end
      id_top    = $urandom_range(1) ? 31 : 7;
      tie_prios = 1'($urandom_range(1));
      no_idle   = ($urandom_range(3) == 0);
      repeat ($urandom_range(40, 80)) begin
        draw = $urandom_range(99);
        if (draw < ins_weight) op = MODE_INSERT;
        else if (draw < ins_weight + 8) op = MODE_PEEK;
        else if (draw % 2) op = MODE_POP_HEAD;
        else op = MODE_REMOVE_ID;
        pid = id_t'($urandom_range(id_top));
        if (tie_prios) pri = 8'($urandom_range(3) * 85);
        else if ($urandom_range(7) == 0) pri = $urandom_range(1) ? 8'hFF : 8'h00;
        else pri = 8'($urandom);
        send_item(op, pid, pri, no_idle ? 0 : pick_gap());
        random_sent++;
      end
      if (phase_idx == 0 || $urandom_range(2) == 0) wait_until_drained();
      phase_idx++;
    end

    wait_until_drained();
    repeat (4) @(posedge clk);

    $display("Sent %0d items: %0d inserts, %0d head removals, %0d removals by id, %0d peeks.",
             sent_per_mode[MODE_INSERT] + sent_per_mode[MODE_POP_HEAD]
             + sent_per_mode[MODE_REMOVE_ID] + sent_per_mode[MODE_PEEK],
             sent_per_mode[MODE_INSERT], sent_per_mode[MODE_POP_HEAD],
             sent_per_mode[MODE_REMOVE_ID], sent_per_mode[MODE_PEEK]);
    $display("Checked %0d results, %0d of them inserts refused on a full queue.",
             replies_checked, full_refusals);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
